// File: src/stsched_pkg.sv
// Package for the second timer scheduler: sizes, command and status codes,
// sequencer states. No dependencies.
`timescale 1ns / 1ps
package stsched_pkg;
   localparam int unsigned PERIODIC_SLOTS = 16;
   localparam int unsigned ONESHOT_SLOTS  = 16;
   localparam int unsigned ID_BITS        = 8;
   localparam int unsigned PIDX_BITS = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
   localparam int unsigned OIDX_BITS = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;

   typedef enum logic [2:0] {
      CMD_ADD_ONESHOT = 3'd0,
      CMD_DEL_ONESHOT = 3'd1,
      CMD_ADD_PERIODIC = 3'd2,
      CMD_DEL_PERIODIC = 3'd3,
      CMD_TICK = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_DUP = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL = 3'd3,
      ST_ZERO = 3'd4
   } status_type;

   // IDLE, table ops, periodic modulo per entry, ordered emission
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MOD, S_PSEL, S_OSEL, S_EMIT, S_DONE
   } state_type;
endpackage

// File: src/stsched_rem.sv
// Iterative unsigned remainder unit, one bit per cycle.
// Depends on stsched_pkg.
`timescale 1ns / 1ps
module stsched_rem
   import stsched_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic        zero_rem
);
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[31:0], quo_ff[31]} - {1'b0, divisor};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (!trial[32]) rem_in = trial;
         else            rem_in = {rem_ff[31:0], quo_ff[31]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd31) && !start;
   assign zero_rem = (rem_in[31:0] == 32'd0);
endmodule

// File: src/second_timer_scheduler_top.sv
// Top level of the second timer scheduler: tables, sequencer, result register.
// Depends on stsched_pkg and stsched_rem.
`timescale 1ns / 1ps
//
// channel | dir | tdata fields (low bit up)                         | tuser
// req_    | in  | command[2:0] timer_id[10:3] amount[42:11] now[74:43] | -
// rsp_    | out | status[2:0] fired_valid[3] fired_id[11:4] cur[43:12] | - ; tlast end_of_run
//
// Add and delete scan the table of their kind, one scan step per slot.
// A tick starts the remainder unit on each valid periodic entry with a nonzero key
// and steps past the other slots, then finds each emitted id by a minimum search
// (one slot a cycle, plus the emit step); one more search per table finds it exhausted.
// Reset (synchronous, high) empties both tables and clears the second.
// req_tready is high only in idle; results wait in the output register while
// rsp_tready is low and the sequencer holds.
module second_timer_scheduler_top
   import stsched_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // command, timer_id, amount, now_second
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // status, fired_valid, fired_id, current_second
   output logic         rsp_tlast   // end_of_run
);
   // tables
   logic [PERIODIC_SLOTS-1:0] pv_ff, pv_in, pf_ff, pf_in;
   logic [31:0]               pk_ff [PERIODIC_SLOTS];
   logic [ID_BITS-1:0]        pid_ff [PERIODIC_SLOTS];
   logic [ONESHOT_SLOTS-1:0]  ov_ff, ov_in, of_ff, of_in;
   logic [31:0]               ok_ff [ONESHOT_SLOTS];
   logic [ID_BITS-1:0]        oid_ff [ONESHOT_SLOTS];
   logic [31:0]               sec_ff, sec_in;

   state_type state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [31:0]        key_ff, key_in;
   logic [8:0]         idx_ff, idx_in;  // scan index, wide enough to hold the depth
   logic               hit_ff, hit_in, dup_ff, dup_in, fr_ff, fr_in, any_ff, any_in;
   logic [8:0]         free_ff, free_in;  // first free slot, valid with free_ok
   logic               free_ok_ff, free_ok_in;
   // minimum search
   logic               bv_ff, bv_in;
   logic [31:0]        bk_ff, bk_in;
   logic [ID_BITS-1:0] bid_ff, bid_in;
   logic [8:0]         bi_ff, bi_in;

   logic              ov_rsp_ff, ov_rsp_in;
   logic [47:0]       rd_ff, rd_in;
   logic              rl_ff, rl_in;
   logic              rem_start, rem_done;
   logic              zero_rem;

   logic               accept, can_push, push;
   logic [43:0]        push_data;
   logic               push_last;
   logic               wr_p, wr_o;
   logic [31:0]        ckey;
   logic [ID_BITS-1:0] cid;
   logic               cval, cless;
   logic [PIDX_BITS-1:0] pi;
   logic [OIDX_BITS-1:0] oi;
   logic               pend, oend;

   assign pi   = idx_ff[PIDX_BITS-1:0];
   assign oi   = idx_ff[OIDX_BITS-1:0];
   assign pend = (idx_ff == 9'(PERIODIC_SLOTS - 1));
   assign oend = (idx_ff == 9'(ONESHOT_SLOTS - 1));
   assign accept   = req_tvalid && req_tready;
   assign can_push = !ov_rsp_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   stsched_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (sec_ff),
      .divisor  (pk_ff[pi]),
      .done     (rem_done),
      .zero_rem (zero_rem)
   );

   // current candidate for the minimum search
   always_comb begin
      if (state_ff == S_PSEL) begin
         cval = pf_ff[pi];
         ckey = pk_ff[pi];
         cid  = pid_ff[pi];
      end else begin
         cval = of_ff[oi];
         ckey = ok_ff[oi];
         cid  = oid_ff[oi];
      end
      cless = !bv_ff || (ckey < bk_ff) || (ckey == bk_ff && cid < bid_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            if (req_tdata[2:0] == CMD_TICK && req_tdata[74:43] == sec_ff) state_in = S_DONE;
            else if (req_tdata[2:0] == CMD_TICK) state_in = S_MOD;
            else if (req_tdata[2:0] == CMD_ADD_PERIODIC && req_tdata[42:11] == 32'd0)
               state_in = S_DONE;
            else if (req_tdata[2:0] > CMD_TICK) state_in = S_DONE;
            else state_in = S_SCAN;
         end
         S_SCAN: if ((cmd_ff[1] ? pend : oend)) state_in = S_DONE;
         S_MOD: if ((!pv_ff[pi] || pk_ff[pi] == 32'd0 || rem_done) && pend) state_in = S_PSEL;
         S_PSEL: if (pend) state_in = S_EMIT;
         S_OSEL: if (oend) state_in = S_EMIT;
         S_EMIT: if (can_push) begin
            if (!bv_ff) begin
               if (fr_ff) state_in = S_OSEL;  // periodic pass over, try one-shots
               else       state_in = S_DONE;
            end else state_in = fr_ff ? S_PSEL : S_OSEL;
         end
         S_DONE: if (can_push) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pv_in = pv_ff; pf_in = pf_ff; ov_in = ov_ff; of_in = of_ff;
      sec_in = sec_ff; cmd_in = cmd_ff; id_in = id_ff; key_in = key_ff;
      idx_in = idx_ff; hit_in = hit_ff; dup_in = dup_ff; fr_in = fr_ff; any_in = any_ff;
      free_in = free_ff; free_ok_in = free_ok_ff;
      bv_in = bv_ff; bk_in = bk_ff; bid_in = bid_ff; bi_in = bi_ff;
      rem_start = 1'b0;
      push = 1'b0; push_data = '0; push_last = 1'b0;
      wr_p = 1'b0; wr_o = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd_in = req_tdata[2:0];
            id_in  = req_tdata[3 +: ID_BITS];
            key_in = (req_tdata[2:0] == CMD_ADD_ONESHOT) ? sec_ff + req_tdata[42:11]
                                                         : req_tdata[42:11];
            idx_in = '0; hit_in = 1'b0; dup_in = 1'b0; free_ok_in = 1'b0;
            free_in = '0; any_in = 1'b0; fr_in = 1'b1; bv_in = 1'b0;
            if (req_tdata[2:0] == CMD_TICK && req_tdata[74:43] != sec_ff) begin
               sec_in = req_tdata[74:43];
               pf_in  = '0;
               // due one-shots are marked up front so the periodic pass knows
               // whether its last id ends the run
               for (int k = 0; k < ONESHOT_SLOTS; k++)
                  of_in[k] = ov_ff[k] && (ok_ff[k] <= req_tdata[74:43]);
            end
            // zero divisor never fires; remainder unit is started on valid nonzero keys
         end
         S_SCAN: begin
            if (cmd_ff[1]) begin
               if (pv_ff[pi] && pid_ff[pi] == id_ff) begin
                  if (cmd_ff[0]) begin pv_in[pi] = 1'b0; hit_in = 1'b1; end
                  else if (pk_ff[pi] == key_ff) dup_in = 1'b1;
               end
               if (!pv_ff[pi] && !free_ok_ff) begin free_ok_in = 1'b1; free_in = idx_ff; end
            end else begin
               if (ov_ff[oi] && oid_ff[oi] == id_ff) begin
                  if (cmd_ff[0]) begin ov_in[oi] = 1'b0; hit_in = 1'b1; end
                  else if (ok_ff[oi] == key_ff) dup_in = 1'b1;
               end
               if (!ov_ff[oi] && !free_ok_ff) begin free_ok_in = 1'b1; free_in = idx_ff; end
            end
            idx_in = idx_ff + 9'd1;
         end
         S_MOD: begin
            if (!pv_ff[pi] || pk_ff[pi] == 32'd0 || rem_done) begin
               if (rem_done && zero_rem) pf_in[pi] = 1'b1;
               idx_in = pend ? 9'd0 : idx_ff + 9'd1;
               any_in = 1'b0;
            end else if (!any_ff) begin
               rem_start = 1'b1;
               any_in = 1'b1;
            end
         end
         S_PSEL, S_OSEL: begin
            if (cval && cless) begin
               bv_in = 1'b1; bk_in = ckey; bid_in = cid; bi_in = idx_ff;
            end
            idx_in = (state_ff == S_PSEL ? pend : oend) ? 9'd0 : idx_ff + 9'd1;
         end
         S_EMIT: if (can_push) begin
            bv_in = 1'b0;
            if (bv_ff) begin
               if (fr_ff) pf_in[bi_ff[PIDX_BITS-1:0]] = 1'b0;
               else begin
                  of_in[bi_ff[OIDX_BITS-1:0]] = 1'b0;
                  ov_in[bi_ff[OIDX_BITS-1:0]] = 1'b0;
               end
               // last when nothing further remains in either set
               push = 1'b1;
               push_data = {sec_ff, 8'(bid_ff), 1'b1, ST_OK};
               push_last = fr_ff ? ($countones(pf_ff) == 1 && of_ff == '0) : ($countones(of_ff) == 1);
               any_in = 1'b1;
            end else if (fr_ff) begin
               fr_in = 1'b0;
            end
         end
         // a tick that fired has already sent its last result
         S_DONE: if (can_push && !(cmd_ff == CMD_TICK && any_ff)) begin
            push = 1'b1; push_last = 1'b1;
            if (cmd_ff == CMD_ADD_PERIODIC && key_ff == 32'd0)
               push_data = {sec_ff, 8'd0, 1'b0, ST_ZERO};
            else if (cmd_ff == CMD_DEL_ONESHOT || cmd_ff == CMD_DEL_PERIODIC)
               push_data = {sec_ff, 8'd0, 1'b0, hit_ff ? ST_OK : ST_NOTFOUND};
            else if (cmd_ff == CMD_ADD_ONESHOT || cmd_ff == CMD_ADD_PERIODIC) begin
               if (dup_ff) push_data = {sec_ff, 8'd0, 1'b0, ST_DUP};
               else if (!free_ok_ff) push_data = {sec_ff, 8'd0, 1'b0, ST_FULL};
               else begin
                  push_data = {sec_ff, 8'd0, 1'b0, ST_OK};
                  if (cmd_ff[1]) begin wr_p = 1'b1; pv_in[free_ff[PIDX_BITS-1:0]] = 1'b1; end
                  else begin wr_o = 1'b1; ov_in[free_ff[OIDX_BITS-1:0]] = 1'b1; end
               end
            end else push_data = {sec_ff, 8'd0, 1'b0, ST_OK};
         end
         default: ;
      endcase
      // the one-shot pass follows a pass that might have emitted nothing
      if (state_ff == S_EMIT && can_push && bv_ff && !fr_ff && $countones(of_ff) == 1)
         push_last = 1'b1;
      ov_rsp_in = ov_rsp_ff; rd_in = rd_ff; rl_in = rl_ff;
      if (ov_rsp_ff && rsp_tready) ov_rsp_in = 1'b0;
      if (push) begin ov_rsp_in = 1'b1; rd_in = {4'd0, push_data}; rl_in = push_last; end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pv_ff <= '0; ov_ff <= '0; pf_ff <= '0; of_ff <= '0;
         sec_ff <= '0; ov_rsp_ff <= 1'b0;
         any_ff <= 1'b0; fr_ff <= 1'b0; bv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff <= pv_in; ov_ff <= ov_in; pf_ff <= pf_in; of_ff <= of_in;
         sec_ff <= sec_in; ov_rsp_ff <= ov_rsp_in;
         any_ff <= any_in; fr_ff <= fr_in; bv_ff <= bv_in;
      end
      cmd_ff <= cmd_in; id_ff <= id_in; key_ff <= key_in; idx_ff <= idx_in;
      hit_ff <= hit_in; dup_ff <= dup_in; free_ff <= free_in; free_ok_ff <= free_ok_in;
      bk_ff <= bk_in; bid_ff <= bid_in; bi_ff <= bi_in;
      rd_ff <= rd_in; rl_ff <= rl_in;
      if (wr_p) begin
         pk_ff[free_ff[PIDX_BITS-1:0]]  <= key_ff;
         pid_ff[free_ff[PIDX_BITS-1:0]] <= id_ff;
      end
      if (wr_o) begin
         ok_ff[free_ff[OIDX_BITS-1:0]]  <= key_ff;
         oid_ff[free_ff[OIDX_BITS-1:0]] <= id_ff;
      end
   end

   assign rsp_tvalid = ov_rsp_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tlast  = rl_ff;

   // fired ids only come out of the emit step
   a_fired_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && rsp_tdata[3] |-> $past(state_ff == S_EMIT))
      else $error("fired result outside emit");
   // no new transaction while a result is still being built
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while busy");
   // periodic firing marks only on valid entries
   a_pf: assert property (@(posedge clock) disable iff (reset)
      (pf_ff & ~pv_ff) == '0)
      else $error("fire mark on empty slot");
endmodule
